// ===== rtl/core/c32mh_pkg.sv =====
package c32mh_pkg;

    // reflected CRC-32C polynomial and finishing multiplier
    localparam logic [31:0] CRC_POLY   = 32'h82f63b78;
    localparam logic [31:0] FINISH_MUL = 32'h805204f3;
    localparam logic [7:0]  BYTE_MASK  = 8'hFF;
    localparam int unsigned MIX_SHIFT  = 16;

    // register indexes
    localparam logic REG_SEED = 1'b0;

    // largest byte count of one word
    localparam logic [2:0] WORD_BYTES = 3'd4;

    // finished message request passed from front to back
    typedef struct packed {
        logic [31:0] crc;
        logic [63:0] len;
        logic        ovf;
    } t_job;

    // finished hash request passed to the output queue
    typedef struct packed {
        logic [31:0] hash;
        logic        ovf;
    } t_result;

    // fold one byte through the reflected CRC
    function automatic logic [31:0] fold_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data & BYTE_MASK};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // fold four bytes, low byte first
    function automatic logic [31:0] fold_word(input logic [31:0] crc, input logic [31:0] data);
        logic [31:0] c;
        c = crc;
        for (int b = 0; b < 4; b++) begin
            c = fold_byte(c, data[8*b +: 8]);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/crc32c_message_hash.sv =====
// Channel   | Ports                                          | Handshake
// ----------+------------------------------------------------+---------------------------
// input     | i_data_word, i_byte_count, i_last              | push / full
// result    | o_hash_value, o_length_overflow                | empty / pop
// config    | paddr, pwdata, prdata (seed at address 0)      | psel, penable, pwrite, pready
//
// One word is accepted every cycle while full is low; the CRC fold of a word is a
// combinational xor network. A result passes a queue handoff, two stages folding the
// 64-bit length, one multiply stage, then a two-entry output queue.
// Reset (synchronous, active low) clears message state, queues and the seed register.
// A full output queue stalls the back pipeline; words keep flowing into the front until
// the two-entry handoff queue fills, which then raises full.
module crc32c_message_hash #(
    parameter int LENGTH_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_hash_value,
    output logic        o_length_overflow,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [31:0]          r_seed;
    c32mh_pkg::t_job      w_job_in, w_job_out;
    logic                 w_job_push, w_job_empty, w_job_pop;
    c32mh_pkg::t_result   w_res_in, w_res_out;
    logic                 w_res_push, w_res_full;

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == c32mh_pkg::REG_SEED) ? r_seed : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (psel && penable && pwrite && (paddr[2] == c32mh_pkg::REG_SEED)) begin
            r_seed <= pwdata;
        end
    end

    // word folding and length count
    c32mh_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed       (r_seed),
        .i_push       (push),
        .i_full       (full),
        .i_data_word  (i_data_word),
        .i_byte_count (i_byte_count),
        .i_last       (i_last),
        .o_job_push   (w_job_push),
        .o_job        (w_job_in)
    );

    // handoff queue between front and back
    c32mh_fifo #(
        .WIDTH ($bits(c32mh_pkg::t_job)),
        .DEPTH (2)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_data  (w_job_in),
        .o_full  (full),
        .i_pop   (w_job_pop),
        .o_data  (w_job_out),
        .o_empty (w_job_empty)
    );

    // length fold and finish
    c32mh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_job_out),
        .i_job_valid (!w_job_empty),
        .o_job_pop   (w_job_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in)
    );

    // result queue
    c32mh_fifo #(
        .WIDTH ($bits(c32mh_pkg::t_result)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_out),
        .o_empty (empty)
    );

    assign o_hash_value      = w_res_out.hash;
    assign o_length_overflow = w_res_out.ovf;

endmodule

// ===== rtl/core/c32mh_fifo.sv =====
module c32mh_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;
    logic             w_wr_en, w_rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign w_wr_en = i_push && !o_full;
    assign w_rd_en = i_pop && !o_empty;

    // pointer and fill count update
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_wr_en) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (w_rd_en) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (w_wr_en && !w_rd_en) begin
            n_count = r_count + CW'(1);
        end else if (!w_wr_en && w_rd_en) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // fill count never passes the depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fifo count beyond depth");

endmodule

// ===== rtl/core/c32mh_front.sv =====
module c32mh_front #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [31:0]         i_seed,
    input  logic                i_push,
    input  logic                i_full,
    input  logic [31:0]         i_data_word,
    input  logic [2:0]          i_byte_count,
    input  logic                i_last,
    output logic                o_job_push,
    output c32mh_pkg::t_job     o_job
);
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    logic [31:0]            r_crc, n_crc;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic                   r_mid, n_mid;
    logic                   r_ovf, n_ovf;

    logic                   w_acc;
    logic [2:0]             w_cnt;
    logic [31:0]            w_mask;
    logic [31:0]            w_base_crc;
    logic [LENGTH_BITS-1:0] w_base_len;
    logic                   w_base_ovf;
    logic [LENGTH_BITS:0]   w_sum;
    logic [31:0]            w_crc;
    logic [LENGTH_BITS-1:0] w_len;
    logic                   w_ovf;

    assign w_acc = i_push && !i_full;

    // clamp count and build the byte mask
    always_comb begin
        w_cnt = (i_byte_count > c32mh_pkg::WORD_BYTES) ? c32mh_pkg::WORD_BYTES : i_byte_count;
        case (w_cnt)
            3'd1:    w_mask = 32'h0000_00FF;
            3'd2:    w_mask = 32'h0000_FFFF;
            3'd3:    w_mask = 32'h00FF_FFFF;
            3'd4:    w_mask = 32'hFFFF_FFFF;
            default: w_mask = 32'h0000_0000;
        endcase
    end

    // message start loads seed, zero length
    assign w_base_crc = r_mid ? r_crc : i_seed;
    assign w_base_len = r_mid ? r_len : '0;
    assign w_base_ovf = r_mid && r_ovf;
    assign w_sum      = {1'b0, w_base_len} + (LENGTH_BITS + 1)'(w_cnt);

    // fold the word and count bytes, saturating on carry out
    always_comb begin
        w_crc = w_base_crc;
        w_len = w_base_len;
        w_ovf = w_base_ovf;
        if (w_cnt != 3'd0) begin
            w_crc = c32mh_pkg::fold_word(w_base_crc, i_data_word & w_mask);
            if (w_sum[LENGTH_BITS]) begin
                w_len = LEN_MAX;
                w_ovf = 1'b1;
            end else begin
                w_len = w_sum[LENGTH_BITS-1:0];
            end
        end
    end

    // next message state
    always_comb begin
        n_crc = r_crc;
        n_len = r_len;
        n_mid = r_mid;
        n_ovf = r_ovf;
        if (w_acc) begin
            if (i_last) begin
                n_crc = '0;
                n_len = '0;
                n_mid = 1'b0;
                n_ovf = 1'b0;
            end else begin
                n_crc = w_crc;
                n_len = w_len;
                n_mid = 1'b1;
                n_ovf = w_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= '0;
            r_len <= '0;
            r_mid <= 1'b0;
            r_ovf <= 1'b0;
        end else begin
            r_crc <= n_crc;
            r_len <= n_len;
            r_mid <= n_mid;
            r_ovf <= n_ovf;
        end
    end

    // finished message goes to the back
    assign o_job_push = w_acc && i_last;
    assign o_job.crc  = w_crc;
    assign o_job.len  = 64'(w_len);
    assign o_job.ovf  = w_ovf;

    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_last) |=> !r_mid && r_len == '0)
        else $error("message state not cleared after last word");

    a_word_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !i_last) |=> r_mid)
        else $error("message not open after inner word");

    a_ovf_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_mid && r_len == LEN_MAX))
        else $error("overflow flag without saturated length");

endmodule

// ===== rtl/core/c32mh_back.sv =====
module c32mh_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  c32mh_pkg::t_job      i_job,
    input  logic                 i_job_valid,
    output logic                 o_job_pop,
    input  logic                 i_res_full,
    output logic                 o_res_push,
    output c32mh_pkg::t_result   o_res
);
    // stage 1: low length word folded
    logic        r_v1;
    logic [31:0] r_crc1;
    logic [31:0] r_len_hi;
    logic        r_ovf1;
    // stage 2: high length word folded
    logic        r_v2;
    logic [31:0] r_crc2;
    logic        r_ovf2;
    // stage 3: finishing product
    logic        r_v3;
    logic [31:0] r_prod;
    logic        r_ovf3;

    logic        w_rdy1, w_rdy2, w_rdy3;
    logic [31:0] w_prod;

    // each stage loads when empty or draining
    assign w_rdy3     = !r_v3 || !i_res_full;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign o_job_pop  = i_job_valid && w_rdy1;
    // low half of the product only
    assign w_prod     = r_crc2 * c32mh_pkg::FINISH_MUL;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_job_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_crc1   <= c32mh_pkg::fold_word(i_job.crc, i_job.len[31:0]);
            r_len_hi <= i_job.len[63:32];
            r_ovf1   <= i_job.ovf;
        end
        if (w_rdy2) begin
            r_crc2 <= c32mh_pkg::fold_word(r_crc1, r_len_hi);
            r_ovf2 <= r_ovf1;
        end
        if (w_rdy3) begin
            r_prod <= w_prod;
            r_ovf3 <= r_ovf2;
        end
    end

    // final xor mix into the output queue
    assign o_res_push = r_v3 && !i_res_full;
    assign o_res.hash = r_prod ^ (r_prod >> c32mh_pkg::MIX_SHIFT);
    assign o_res.ovf  = r_ovf3;

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && i_res_full) |=> (r_v3 && $stable(r_prod) && $stable(r_ovf3)))
        else $error("finished hash lost during stall");

endmodule

// ===== verif/crc32c_message_hash_test.sv =====
`timescale 1ns / 100ps

module crc32c_message_hash_test;

    // length counter width the bench runs the block at
    localparam int          HASH_LEN_BITS = 16;
    localparam logic [63:0] LEN_MAX       = 64'((65'd1 << HASH_LEN_BITS) - 65'd1);
    localparam logic [2:0]  SEED_ADDR     = {c32mh_pkg::REG_SEED, 2'b00};
    localparam int          SETTLE_CYCLES = 12;
    localparam int          RANDOM_ITEMS  = 370;

    logic        i_clk;
    logic        i_rst_n           = 1'b0;
    logic        push              = 1'b0;
    logic        full;
    logic [31:0] i_data_word       = '0;
    logic [2:0]  i_byte_count      = '0;
    logic        i_last            = 1'b0;
    logic        empty;
    logic        pop               = 1'b0;
    logic [31:0] o_hash_value;
    logic        o_length_overflow;
    logic        psel              = 1'b0;
    logic        penable           = 1'b0;
    logic        pwrite            = 1'b0;
    logic [2:0]  paddr             = '0;
    logic [31:0] pwdata            = '0;
    logic [31:0] prdata;
    logic        pready;

    crc32c_message_hash #(
        .LENGTH_BITS(HASH_LEN_BITS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .full(full),
        .i_data_word(i_data_word),
        .i_byte_count(i_byte_count),
        .i_last(i_last),
        .empty(empty),
        .pop(pop),
        .o_hash_value(o_hash_value),
        .o_length_overflow(o_length_overflow),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // directed stimulus row; fixed rows carry a hand-typed expected hash
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  cnt;
        logic        last;
        logic        fixed;
        logic [31:0] hash;
        logic        ovf;
    } t_stim_row;

    t_stim_row directed_rows [20] = '{
        '{32'h0000_0000, 3'd0, 1'b1, 1'b1, 32'h0000_0000, 1'b0}, // empty message, seed zero
        '{32'hFFFF_FFFF, 3'd4, 1'b1, 1'b0, 32'h0, 1'b0},
        '{32'h0000_0000, 3'd4, 1'b1, 1'b0, 32'h0, 1'b0},
        '{32'hDEAD_BEEF, 3'd1, 1'b1, 1'b0, 32'h0, 1'b0},         // short word
        '{32'hFFFF_FFFF, 3'd2, 1'b1, 1'b0, 32'h0, 1'b0},
        '{32'hFFFF_FFFF, 3'd3, 1'b1, 1'b0, 32'h0, 1'b0},
        '{32'h1234_5678, 3'd7, 1'b1, 1'b0, 32'h0, 1'b0},         // count above four
        '{32'hA5A5_A5A5, 3'd5, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'h5A5A_5A5A, 3'd6, 1'b1, 1'b0, 32'h0, 1'b0},
        '{32'hFFFF_FFFF, 3'd1, 1'b0, 1'b0, 32'h0, 1'b0},         // short word that opens a message
        '{32'h0102_0304, 3'd4, 1'b1, 1'b0, 32'h0, 1'b0},
        '{32'h1111_1111, 3'd0, 1'b0, 1'b0, 32'h0, 1'b0},         // count zero opens message
        '{32'hCAFE_F00D, 3'd4, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'h0000_0000, 3'd0, 1'b1, 1'b0, 32'h0, 1'b0},         // count zero closes message
        '{32'h0302_0100, 3'd4, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'h0706_0504, 3'd4, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'h0B0A_0908, 3'd4, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'h0F0E_0D0C, 3'd4, 1'b1, 1'b0, 32'h0, 1'b0},
        '{32'h8000_0000, 3'd4, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'h0000_0001, 3'd3, 1'b1, 1'b0, 32'h0, 1'b0}
    };

    // predictor state and seed copy
    logic [31:0] seed_reg  = '0;
    logic [31:0] pred_crc  = '0;
    logic [63:0] pred_len  = '0;
    logic        pred_open = 1'b0;
    logic        pred_ovf  = 1'b0;

    c32mh_pkg::t_result hashes_due [$];

    int mismatches    = 0;
    int items_sent    = 0;
    int hashes_seen   = 0;
    int seeds_written = 0;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int rx_hold       = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // reflected CRC-32C over the low nbytes of val, low byte first
    function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [63:0] val,
                                             input int nbytes);
        logic [31:0] c;
        c = crc;
        for (int i = 0; i < nbytes; i++) begin
            c = c ^ {24'd0, val[8*i +: 8]};
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ c32mh_pkg::CRC_POLY) : (c >> 1);
            end
        end
        return c;
    endfunction

    // advance the message hash by one accepted word; yields a hash on the last word
    task automatic hash_predict_word(input logic [31:0] w, input logic [2:0] c, input logic l,
                                     output bit made, output c32mh_pkg::t_result due);
        logic [31:0] word;
        logic [2:0]  n;
        logic [31:0] mixed;
        made = 1'b0;
        due  = '0;
        word = w;
        n    = (c > c32mh_pkg::WORD_BYTES) ? c32mh_pkg::WORD_BYTES : c;
        if (!pred_open) begin
            pred_crc = seed_reg;
            pred_len = '0;
            pred_ovf = 1'b0;
        end
        if (n != 3'd0) begin
            if (n < c32mh_pkg::WORD_BYTES) begin
                word = word & ((32'd1 << (8 * n)) - 32'd1);
            end
            pred_crc = crc_fold(pred_crc, {32'd0, word}, 4);
            if (pred_len > LEN_MAX - 64'(n)) begin
                pred_len = LEN_MAX;
                pred_ovf = 1'b1;
            end else begin
                pred_len = pred_len + 64'(n);
            end
        end
        if (!l) begin
            pred_open = 1'b1;
        end else begin
            mixed     = crc_fold(pred_crc, pred_len, 8) * c32mh_pkg::FINISH_MUL;
            mixed     = mixed ^ (mixed >> c32mh_pkg::MIX_SHIFT);
            due.hash  = mixed;
            due.ovf   = pred_ovf;
            made      = 1'b1;
            pred_crc  = '0;
            pred_len  = '0;
            pred_open = 1'b0;
            pred_ovf  = 1'b0;
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch on %s: expected %h, got %h", what, want, got);
        end
    endtask

    // offer one input request, with random idle first, and wait for acceptance
    task automatic send_item(input logic [31:0] w, input logic [2:0] c, input logic l,
                             output bit made, output c32mh_pkg::t_result due);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push         <= 1'b1;
        i_data_word  <= w;
        i_byte_count <= c;
        i_last       <= l;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        hash_predict_word(w, c, l, made, due);
        items_sent++;
    endtask

    task automatic send_word(input logic [31:0] w, input logic [2:0] c, input logic l);
        bit                 made;
        c32mh_pkg::t_result due;
        send_item(w, c, l, made, due);
        if (made) hashes_due.push_back(due);
    endtask

    // stop offering and wait for every outstanding hash plus pipeline settle
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (hashes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write of the seed, then read it back
    task automatic set_seed(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SEED_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        seed_reg = value;
        seeds_written++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== seed_reg) flag_mismatch("seed readback", seed_reg, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // random messages: mostly well formed, some empty, some short or oversized counts mid-message or at the end
    task automatic run_random(input int n_items, input bit hold_midway);
        int start;
        int words;
        bit held;
        logic [2:0] c;
        start = items_sent;
        held  = 1'b0;
        while (items_sent - start < n_items) begin
            if (hold_midway && !held && (items_sent - start) >= n_items / 2) begin
                rx_hold = 400;
                held    = 1'b1;
            end
            if ($urandom_range(99) < 8) begin
                send_word($urandom(), 3'd0, 1'b1);
            end else begin
                words = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 8);
                for (int i = 0; i < words - 1; i++) begin
                    c = ($urandom_range(19) == 0) ? 3'($urandom_range(7))
                                                  : c32mh_pkg::WORD_BYTES;
                    send_word($urandom(), c, 1'b0);
                end
                c = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
                send_word($urandom(), c, 1'b1);
            end
        end
    endtask

    // result side: check each popped hash against the oldest expectation
    initial begin
        c32mh_pkg::t_result want;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                hashes_seen++;
                if (hashes_due.size() == 0) begin
                    flag_mismatch("unexpected hash", 32'h0, o_hash_value);
                end else begin
                    want = hashes_due.pop_front();
                    if (o_hash_value !== want.hash) begin
                        flag_mismatch("hash_value", want.hash, o_hash_value);
                    end
                    if (o_length_overflow !== want.ovf) begin
                        flag_mismatch("length_overflow", 32'(want.ovf), 32'(o_length_overflow));
                    end
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // main sequence
    initial begin
        bit                 made;
        c32mh_pkg::t_result due;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // seed after reset, then the directed table at seed zero
        tx_idle_pct = 28;
        rx_idle_pct = 69;
        set_seed(32'h0000_0000);
        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].word, directed_rows[i].cnt, directed_rows[i].last,
                      made, due);
            if (made) begin
                if (directed_rows[i].fixed) begin
                    due.hash = directed_rows[i].hash;
                    due.ovf  = directed_rows[i].ovf;
                end
                hashes_due.push_back(due);
            end
        end

        // leave a message open across the seed change
        send_word($urandom(), c32mh_pkg::WORD_BYTES, 1'b0);
        wait_drained();
        set_seed(32'hFFFF_FFFF);
        run_random(RANDOM_ITEMS, 1'b1);

        send_word($urandom(), c32mh_pkg::WORD_BYTES, 1'b0);
        wait_drained();
        set_seed($urandom());
        tx_idle_pct = 69;
        rx_idle_pct = 28;
        run_random(RANDOM_ITEMS / 2, 1'b0);
        wait_drained();
        run_random(RANDOM_ITEMS / 2, 1'b0);

        // full rate on both sides
        wait_drained();
        set_seed(32'h0000_0000);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(RANDOM_ITEMS, 1'b0);

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("covered %0d input words and %0d hashes under %0d seed settings",
                 items_sent, hashes_seen, seeds_written);
        $display("including short and empty words, mid-message seed change, long output stall");
        if (mismatches == 0 && hashes_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
